// ----- rtl/scg_pkg.sv -----
package scg_pkg;

  // Channel types selected by the configuration register
  typedef enum logic [1:0] {
    CH_SWEEP_SQUARE = 2'd0,
    CH_SQUARE       = 2'd1,
    CH_WAVE         = 2'd2,
    CH_NOISE        = 2'd3
  } chan_type_t;

  // Input operation codes as they arrive on the op port
  localparam logic [1:0] OP_REG_WRITE  = 2'd0;
  localparam logic [1:0] OP_TICK       = 2'd1;
  localparam logic [1:0] OP_FRAME      = 2'd2;
  localparam logic [1:0] OP_WAVE_WRITE = 2'd3;

  // Channel register byte indexes
  localparam logic [2:0] REG_SWEEP    = 3'd0;
  localparam logic [2:0] REG_LEN_DUTY = 3'd1;
  localparam logic [2:0] REG_ENVELOPE = 3'd2;
  localparam logic [2:0] REG_FREQ_LO  = 3'd3;
  localparam logic [2:0] REG_FREQ_HI  = 3'd4;
  localparam int         NUM_REGS     = 5;

  // Frame sequencer step that clocks the envelope
  localparam logic [2:0] ENV_STEP = 3'd7;

  localparam int WAVE_BYTES      = 16;
  localparam int SCG_QUEUE_DEPTH = 4;

  localparam logic [11:0] TONE_LIMIT  = 12'h7ff;
  localparam logic [11:0] PERIOD_BASE = 12'h800;

  localparam logic [7:0] DUTY_PATTERN [4] = '{8'h01, 8'h81, 8'h87, 8'h7e};
  localparam logic [5:0] NOISE_BASE [8] =
    '{6'd4, 6'd8, 6'd16, 6'd24, 6'd32, 6'd40, 6'd48, 6'd56};
  localparam logic [2:0] WAVE_SHIFT_CODE [4] = '{3'd4, 3'd0, 3'd1, 3'd2};

  // Classified command handed from the front end to the channel core
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_REG_WRITE,
    CMD_TICK,
    CMD_FRAME,
    CMD_WAVE_WRITE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  sel;    // register index or frame step
    logic [3:0]  addr;   // wave table address
    logic [7:0]  data;
  } cmd_t;

  // Queue head as seen by the channel core
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ----- rtl/scg_front.sv -----
module scg_front
  import scg_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [2:0] reg_index,
  input  logic [7:0] data,
  input  logic [2:0] frame_index,
  input  logic [3:0] wave_index,
  input  logic       push_ready,
  output logic       push,
  output cmd_t       cmd
);

  // Accept a word whenever the queue has room
  assign in_stall = !push_ready;
  assign push     = in_valid && push_ready;

  // Classify the word; writes beyond the last register become no-ops
  always_comb begin
    cmd.addr = wave_index;
    cmd.data = data;
    cmd.sel  = reg_index;
    unique case (op)
      OP_REG_WRITE: begin
        cmd.kind = (reg_index <= REG_FREQ_HI) ? CMD_REG_WRITE : CMD_NOP;
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
      end
      OP_FRAME: begin
        cmd.kind = CMD_FRAME;
        cmd.sel  = frame_index;
      end
      OP_WAVE_WRITE: begin
        cmd.kind = CMD_WAVE_WRITE;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

// ----- rtl/scg_queue.sv -----
module scg_queue
  import scg_pkg::*;
#(
  parameter int DEPTH = SCG_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    push_ready,
  input  logic    pop,
  output q_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign push_ready = count != CW'(DEPTH);
  assign head.valid = count != '0;
  assign head.cmd   = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/scg_core.sv -----
module scg_core
  import scg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  q_head_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] level,
  output logic       enabled
);

  // One sweep calculation: shift, add or subtract, saturate
  function automatic logic [11:0] sweep_calc(input logic [11:0] f, input logic [7:0] r0);
    logic [11:0] delta;
    logic [12:0] sum;
    delta = f >> r0[2:0];
    sum   = {1'b0, f} + {1'b0, delta};
    if (r0[3]) begin
      return f - delta;
    end
    return sum[12] ? 12'hfff : sum[11:0];
  endfunction

  chan_type_t  channel_type;
  logic [7:0]  regs [NUM_REGS];
  logic [7:0]  wave_table [WAVE_BYTES];
  logic        sounding;
  logic [20:0] period_count;
  logic [14:0] noise_shift;
  logic [4:0]  wave_pos;
  logic [3:0]  volume;
  logic [2:0]  envelope_count;
  logic [8:0]  length_count;
  logic [11:0] shadow_freq;
  logic [2:0]  sweep_count;
  logic        sweep_active;
  logic [3:0]  out_level;

  logic [7:0]  regs_next [NUM_REGS];
  logic        sounding_next;
  logic [20:0] period_count_next;
  logic [14:0] noise_shift_next;
  logic [4:0]  wave_pos_next;
  logic [3:0]  volume_next;
  logic [2:0]  envelope_count_next;
  logic [8:0]  length_count_next;
  logic [11:0] shadow_freq_next;
  logic [2:0]  sweep_count_next;
  logic        sweep_active_next;
  logic [3:0]  out_level_next;

  logic        is_wave;
  logic [10:0] tone;
  logic [11:0] tone_gap;
  logic [11:0] sf;
  logic [7:0]  wbyte;
  logic [3:0]  nibble;
  logic        fb;
  logic [20:0] noise_period;
  cmd_t        c;

  // Take the queue head when the output register is free or being drained
  assign pop     = head.valid && (!out_valid || !out_stall);
  assign c       = head.cmd;
  assign is_wave = channel_type == CH_WAVE;

  // Execute one command against the channel state
  always_comb begin
    regs_next           = regs;
    sounding_next       = sounding;
    period_count_next   = period_count;
    noise_shift_next    = noise_shift;
    wave_pos_next       = wave_pos;
    volume_next         = volume;
    envelope_count_next = envelope_count;
    length_count_next   = length_count;
    shadow_freq_next    = shadow_freq;
    sweep_count_next    = sweep_count;
    sweep_active_next   = sweep_active;
    out_level_next      = out_level;
    tone         = {regs[REG_FREQ_HI][2:0], regs[REG_FREQ_LO]};
    tone_gap     = PERIOD_BASE - {1'b0, tone};
    sf           = '0;
    wbyte        = '0;
    nibble       = '0;
    fb           = noise_shift[0] ^ noise_shift[1];
    noise_period = ({15'b0, NOISE_BASE[regs[REG_FREQ_LO][2:0]]} << regs[REG_FREQ_LO][7:4])
                   + 21'd1;

    unique case (c.kind)
      CMD_REG_WRITE: begin
        regs_next[c.sel] = c.data;
        if (is_wave) begin
          if (c.sel == REG_SWEEP && !c.data[7]) begin
            sounding_next = 1'b0;
          end
          if (c.sel == REG_LEN_DUTY) begin
            length_count_next = 9'd256 - {1'b0, c.data};
          end
          if (c.sel == REG_ENVELOPE) begin
            volume_next = {1'b0, WAVE_SHIFT_CODE[c.data[6:5]]};
          end
        end else if (c.sel == REG_LEN_DUTY) begin
          length_count_next = 9'd64 - {3'b0, c.data[5:0]};
        end
        // Trigger restarts the channel
        if (c.sel == REG_FREQ_HI && c.data[7]) begin
          sounding_next       = 1'b1;
          period_count_next   = 21'd1;
          noise_shift_next    = 15'h00ff;
          envelope_count_next = regs_next[REG_ENVELOPE][2:0];
          if (is_wave) begin
            wave_pos_next = '0;
          end
          if (length_count_next == '0) begin
            length_count_next = is_wave ? 9'd256 : 9'd64;
          end
          if (!is_wave) begin
            volume_next = regs_next[REG_ENVELOPE][7:4];
          end
          if (channel_type == CH_SWEEP_SQUARE) begin
            shadow_freq_next  = {1'b0, regs_next[REG_FREQ_HI][2:0], regs_next[REG_FREQ_LO]};
            sweep_count_next  = regs_next[REG_SWEEP][6:4];
            sweep_active_next = regs_next[REG_SWEEP][6:4] != '0 ||
                                regs_next[REG_SWEEP][2:0] != '0;
            if (regs_next[REG_SWEEP][2:0] != '0) begin
              sf               = sweep_calc(shadow_freq_next, regs_next[REG_SWEEP]);
              shadow_freq_next = sf;
              if (sf > TONE_LIMIT) begin
                sounding_next = 1'b0;
              end
            end
          end
        end
      end

      CMD_TICK: begin
        period_count_next = period_count - 21'd1;
        if (period_count_next == '0) begin
          unique case (channel_type)
            CH_SWEEP_SQUARE, CH_SQUARE: begin
              period_count_next = {8'b0, tone_gap, 1'b1};
              wave_pos_next     = {2'b0, wave_pos[2:0] + 3'd1};
              out_level_next    =
                (sounding && DUTY_PATTERN[regs[REG_LEN_DUTY][7:6]][wave_pos_next[2:0]])
                ? volume : 4'd0;
            end
            CH_WAVE: begin
              period_count_next = {9'b0, tone_gap} + 21'd1;
              wave_pos_next     = wave_pos + 5'd1;
              wbyte             = wave_table[wave_pos_next[4:1]];
              nibble            = wave_pos_next[0] ? wbyte[7:4] : wbyte[3:0];
              out_level_next    = (sounding && volume < 4'd4) ? (nibble >> volume[1:0]) : 4'd0;
            end
            CH_NOISE: begin
              period_count_next = noise_period;
              noise_shift_next  = {fb, noise_shift[14:1]};
              if (regs[REG_FREQ_LO][3]) begin
                noise_shift_next[6] = fb;
              end
              out_level_next = (sounding && !noise_shift_next[0]) ? volume : 4'd0;
            end
            default: begin
              out_level_next = out_level;
            end
          endcase
        end
      end

      CMD_FRAME: begin
        // Length counter
        if (c.sel[0] && regs[REG_FREQ_HI][6] && length_count != '0) begin
          length_count_next = length_count - 9'd1;
          if (length_count_next == '0) begin
            sounding_next = 1'b0;
          end
        end
        // Volume envelope
        if (c.sel == ENV_STEP && !is_wave && envelope_count != '0) begin
          envelope_count_next = envelope_count - 3'd1;
          if (envelope_count_next == '0) begin
            if (regs[REG_ENVELOPE][3]) begin
              if (volume != 4'hf) begin
                volume_next = volume + 4'd1;
              end
            end else if (volume != '0) begin
              volume_next = volume - 4'd1;
            end
            envelope_count_next = regs[REG_ENVELOPE][2:0];
          end
        end
        // Frequency sweep, applied twice on write-back
        if (c.sel[1:0] == 2'd2 && channel_type == CH_SWEEP_SQUARE && sweep_active &&
            sweep_count != '0) begin
          sweep_count_next = sweep_count - 3'd1;
          if (sweep_count_next == '0) begin
            sweep_count_next = regs[REG_SWEEP][6:4];
            sf               = sweep_calc(shadow_freq, regs[REG_SWEEP]);
            shadow_freq_next = sf;
            if (sf > TONE_LIMIT) begin
              sounding_next = 1'b0;
            end
            if (sounding_next && regs[REG_SWEEP][2:0] != '0) begin
              shadow_freq_next = sweep_calc(sf, regs[REG_SWEEP]);
              if (shadow_freq_next > TONE_LIMIT) begin
                sounding_next = 1'b0;
              end
              regs_next[REG_FREQ_LO]      = shadow_freq_next[7:0];
              regs_next[REG_FREQ_HI][2:0] = shadow_freq_next[10:8];
            end
          end
        end
      end

      CMD_WAVE_WRITE: begin
        out_level_next = out_level;
      end

      default: begin
        out_level_next = out_level;
      end
    endcase
  end

  // Commit channel state on each popped word
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_type   <= CH_SWEEP_SQUARE;
      regs           <= '{default: '0};
      wave_table     <= '{default: '0};
      sounding       <= 1'b0;
      period_count   <= '0;
      noise_shift    <= '0;
      wave_pos       <= '0;
      volume         <= '0;
      envelope_count <= '0;
      length_count   <= '0;
      shadow_freq    <= '0;
      sweep_count    <= '0;
      sweep_active   <= 1'b0;
      out_level      <= '0;
    end else begin
      if (cfg_wr_en) begin
        channel_type <= chan_type_t'(cfg_wr_data);
      end
      if (pop) begin
        regs           <= regs_next;
        sounding       <= sounding_next;
        period_count   <= period_count_next;
        noise_shift    <= noise_shift_next;
        wave_pos       <= wave_pos_next;
        volume         <= volume_next;
        envelope_count <= envelope_count_next;
        length_count   <= length_count_next;
        shadow_freq    <= shadow_freq_next;
        sweep_count    <= sweep_count_next;
        sweep_active   <= sweep_active_next;
        out_level      <= out_level_next;
        if (c.kind == CMD_WAVE_WRITE) begin
          wave_table[c.addr] <= c.data;
        end
      end
    end
  end

  // Output register: hold while stalled, load on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      level   <= out_level_next;
      enabled <= sounding_next;
    end
  end

endmodule

// ----- rtl/sound_channel_generator_top.sv -----
// Channel   Handshake              Payload
// ------    ---------------------  -----------------------------------------
// in        in_valid / in_stall    op, reg_index, data, frame_index, wave_index
// out       out_valid / out_stall  level, enabled
// cfg       cfg_wr_en              cfg_wr_data (channel type)
//
// One word per cycle sustained through the queue and the channel core while out_stall is low.
// The core updates all channel state for a word and loads the output register at
// the same edge at which it pops the word from the queue.
// rst is synchronous and clears all channel state, the queue and the output valid.
// in_stall rises only when the queue is full; out_stall holds the output word and
// backs up the queue.
module sound_channel_generator_top
  import scg_pkg::*;
#(
  parameter int QUEUE_DEPTH = SCG_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [2:0] reg_index,
  input  logic [7:0] data,
  input  logic [2:0] frame_index,
  input  logic [3:0] wave_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] level,
  output logic       enabled
);

  logic    push;
  logic    push_ready;
  logic    pop;
  cmd_t    cmd;
  q_head_t head;

  // Accept and classify input words
  scg_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .reg_index   (reg_index),
    .data        (data),
    .frame_index (frame_index),
    .wave_index  (wave_index),
    .push_ready  (push_ready),
    .push        (push),
    .cmd         (cmd)
  );

  // Decouple front end from channel core
  scg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head)
  );

  // Run the channel and register the result
  scg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level       (level),
    .enabled     (enabled)
  );

endmodule

// ----- rtl/scg_checker.sv -----
module scg_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_wr_en,
  input logic [1:0] cfg_wr_data,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] op,
  input logic [2:0] reg_index,
  input logic [7:0] data,
  input logic [2:0] frame_index,
  input logic [3:0] wave_index,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] level,
  input logic       enabled
);

  // Reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("valid or stall set after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(enabled))
    else $error("output word changed while stalled");

  // The queue fills only through an accepted word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without an accepted word");

  // A free output drains one entry from a full queue
  a_stall_drain: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stall held while output was free");

endmodule

bind sound_channel_generator_top scg_checker u_scg_checker (.*);
